// ===== hw/rtl/fcv_pkg.sv =====
// ----------------------------------------------------------------------------
// fcv_pkg
// shared types, tables and constants of the frame checksum verifier
// ----------------------------------------------------------------------------
package fcv_pkg;

  localparam int unsigned FRAME_W  = 64;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam int signed DYN_OFFSET = 509;

  // residual codes of the decision tree
  localparam logic [7:0] PRED_STARTUP_FF  = 8'h0D;
  localparam logic [7:0] PRED_STARTUP_7X  = 8'hB4;
  localparam logic [7:0] PRED_B4_FF       = 8'h0D;
  localparam logic [7:0] PRED_B4_BX       = 8'h5D;
  localparam logic [7:0] PRED_B4_AX       = 8'h84;
  localparam logic [7:0] PRED_B4_9X_ALT   = 8'hC0;
  localparam logic [7:0] PRED_B4_9X       = 8'h1E;
  localparam logic [7:0] PRED_LOW_NEG     = 8'h25;
  localparam logic [7:0] PRED_LOW_POS     = 8'h5E;
  localparam logic [7:0] PRED_MID_NEG     = 8'hF6;
  localparam logic [7:0] PRED_MID_POS     = 8'h8D;
  localparam logic [7:0] PRED_HIGH_NEG    = 8'hBC;
  localparam logic [7:0] PRED_HIGH_ST     = 8'h14;
  localparam logic [7:0] PRED_HIGH_B4     = 8'h19;
  localparam logic [7:0] PRED_HIGH        = 8'hC7;
  localparam logic [7:0] PRED_OVL_LOW     = 8'h62;
  localparam logic [7:0] PRED_OVL_HIGH    = 8'h38;

  // byte-5 alternate families
  localparam logic [7:0] B5_NOMINAL = 8'h64;
  localparam logic [7:0] B5_FAM_63  = 8'h63;
  localparam logic [7:0] B5_FAM_62  = 8'h62;
  localparam logic [7:0] B5_FAM_61  = 8'h61;
  localparam logic [7:0] B5_FAM_60  = 8'h60;
  localparam logic [7:0] FAM_63_XOR = 8'h7A;
  localparam logic [7:0] FAM_62_XOR = 8'hCF;
  localparam logic [7:0] FAM_61_XOR = 8'h3F;
  localparam logic [7:0] FAM_60_XOR = 8'h8A;

  localparam logic [15:0] SPEED_HIGH_Q = 16'd8192;

  localparam logic [7:0] CTR_TAB [16] = '{
    8'h00, 8'h7A, 8'h96, 8'h79, 8'hD5, 8'hBF, 8'h8F, 8'h9A,
    8'hB8, 8'hCA, 8'h95, 8'h58, 8'h46, 8'h55, 8'hE7, 8'h68
  };

  // one row per payload byte 2..7, one vector per bit
  localparam logic [7:0] LIN_TAB [6][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h9B, 8'h19, 8'h32},
    '{8'h54, 8'hA8, 8'h7F, 8'hFE, 8'h00, 8'h00, 8'h3D, 8'h7A},
    '{8'hAD, 8'h75, 8'hEA, 8'hFB, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hEF, 8'hF1, 8'hCD},
    '{8'hE9, 8'hFD, 8'hD5, 8'h85, 8'h25, 8'h00, 8'h00, 8'h00}
  };

  typedef struct packed {
    logic [7:0]         pred;
    logic [15:0]        speed_quarter;
    logic [8:0]         status_field;
    logic signed [10:0] dynamic_value;
  } pred_info_t;

  typedef struct packed {
    logic signed [10:0] dynamic_value;
    logic [8:0]         status_field;
    logic [15:0]        speed_quarter;
    logic [7:0]         predicted_residual;
    logic [7:0]         actual_residual;
    logic               checksum_ok;
  } result_t;

endpackage

// ===== hw/rtl/fcv_actual.sv =====
// ----------------------------------------------------------------------------
// fcv_actual
// xor network giving the actual residual of one frame
// ----------------------------------------------------------------------------
module fcv_actual (
  input  logic [fcv_pkg::FRAME_W-1:0] frame,
  output logic [7:0]                  actual_residual
);

  always_comb begin
    logic [7:0] r;
    r = frame[7:0] ^ fcv_pkg::CTR_TAB[frame[11:8]];
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 8; k++) begin
        if (frame[16 + 8*i + k]) begin
          r = r ^ fcv_pkg::LIN_TAB[i][k];
        end
      end
    end
    actual_residual = r;
  end

endmodule

// ===== hw/rtl/fcv_predict.sv =====
// ----------------------------------------------------------------------------
// fcv_predict
// field decode and decision tree for the predicted residual
// ----------------------------------------------------------------------------
module fcv_predict (
  input  logic [fcv_pkg::FRAME_W-1:0] frame,
  output fcv_pkg::pred_info_t         info
);

  logic [7:0]         b4, b5, b6, b7;
  logic [15:0]        spd;
  logic [8:0]         st;
  logic [9:0]         dy_raw;
  logic signed [10:0] dy;
  logic               startup;
  logic               neg, high, mid;
  logic [7:0]         p_tree, p_fam, p_fin;

  assign b4     = frame[39:32];
  assign b5     = frame[47:40];
  assign b6     = frame[55:48];
  assign b7     = frame[63:56];
  assign spd    = frame[63:48];
  assign st     = frame[29:21];
  assign dy_raw = frame[39:30];
  assign dy     = $signed({1'b0, dy_raw}) - 11'(fcv_pkg::DYN_OFFSET);

  assign startup = (b5 == 8'h00) && (b6 == 8'h00) && (b7 == 8'h00);
  assign neg     = dy < 11'sd3;
  assign high    = spd >= fcv_pkg::SPEED_HIGH_Q;
  assign mid     = st >= 9'd128;

  always_comb begin
    if (b4 == 8'hFF) begin
      p_tree = fcv_pkg::PRED_B4_FF;
    end else if (b4 >= 8'hB0 && b4 <= 8'hBF) begin
      p_tree = fcv_pkg::PRED_B4_BX;
    end else if (b4 >= 8'hA0 && b4 <= 8'hAF) begin
      p_tree = fcv_pkg::PRED_B4_AX;
    end else if (b4 >= 8'h91 && b4 <= 8'h98 && b5 == fcv_pkg::B5_NOMINAL &&
                 st >= 9'd247 && dy >= 11'sd72) begin
      p_tree = fcv_pkg::PRED_B4_9X_ALT;
    end else if (b4 >= 8'h99 && b4 <= 8'h9F && b7 >= 8'h40) begin
      p_tree = fcv_pkg::PRED_B4_9X_ALT;
    end else if (b4 >= 8'h90 && b4 <= 8'h9F) begin
      p_tree = fcv_pkg::PRED_B4_9X;
    end else if (!high) begin
      if (!mid) begin
        p_tree = neg ? fcv_pkg::PRED_LOW_NEG : fcv_pkg::PRED_LOW_POS;
      end else begin
        p_tree = neg ? fcv_pkg::PRED_MID_NEG : fcv_pkg::PRED_MID_POS;
      end
    end else if (neg) begin
      p_tree = fcv_pkg::PRED_HIGH_NEG;
    end else if (b5 == fcv_pkg::B5_NOMINAL && st >= 9'd121 && st <= 9'd127) begin
      p_tree = fcv_pkg::PRED_HIGH_ST;
    end else if (b5 == fcv_pkg::B5_NOMINAL && b4 >= 8'h80 && b4 <= 8'h86 &&
                 b7 >= 8'h4C) begin
      p_tree = fcv_pkg::PRED_HIGH_B4;
    end else begin
      p_tree = fcv_pkg::PRED_HIGH;
    end
  end

  // alternate xor families selected by byte 5
  always_comb begin
    p_fam = p_tree;
    if (b5 == fcv_pkg::B5_FAM_63) begin
      if (p_tree == fcv_pkg::PRED_LOW_NEG || p_tree == fcv_pkg::PRED_MID_NEG ||
          p_tree == fcv_pkg::PRED_HIGH_NEG || p_tree == fcv_pkg::PRED_HIGH) begin
        p_fam = p_tree ^ fcv_pkg::FAM_63_XOR;
      end
    end else if (p_tree == fcv_pkg::PRED_LOW_NEG || p_tree == fcv_pkg::PRED_HIGH_NEG ||
                 p_tree == fcv_pkg::PRED_HIGH) begin
      if (b5 == fcv_pkg::B5_FAM_62) begin
        p_fam = p_tree ^ fcv_pkg::FAM_62_XOR;
      end else if (b5 == fcv_pkg::B5_FAM_61) begin
        p_fam = p_tree ^ fcv_pkg::FAM_61_XOR;
      end else if (b5 == fcv_pkg::B5_FAM_60) begin
        p_fam = p_tree ^ fcv_pkg::FAM_60_XOR;
      end
    end
  end

  // high-negative overlay, then the startup frame overrides everything
  always_comb begin
    p_fin = p_fam;
    if (p_fam == fcv_pkg::PRED_HIGH_NEG && b7[6:5] == 2'b10) begin
      p_fin = st[8] ? fcv_pkg::PRED_OVL_HIGH : fcv_pkg::PRED_OVL_LOW;
    end
    if (startup && b4 == 8'hFF) begin
      p_fin = fcv_pkg::PRED_STARTUP_FF;
    end else if (startup && b4 >= 8'h76 && b4 <= 8'h7F) begin
      p_fin = fcv_pkg::PRED_STARTUP_7X;
    end
  end

  assign info.pred          = p_fin;
  assign info.speed_quarter = spd;
  assign info.status_field  = st;
  assign info.dynamic_value = dy;

endmodule

// ===== hw/rtl/frame_checksum_verify_top.sv =====
// ----------------------------------------------------------------------------
// frame_checksum_verify_top
// one-byte frame checksum check: residual compare with decoded fields
// ----------------------------------------------------------------------------
// datapath: input register, then result register, to out_tdata
// throughput: one frame per cycle while out_tready is high, set by the input and result registers
// the input register is refilled whenever the result register can take its item
// reset: rst_n synchronous active low, clears both valid flags; data not reset
// ----------------------------------------------------------------------------
module frame_checksum_verify_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // byte_0, byte_1, byte_2, byte_3, byte_4, byte_5, byte_6, byte_7
  input  logic [fcv_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // checksum_ok, actual_residual, predicted_residual, speed_quarter,
  // status_field, dynamic_value, three zero pad bits
  output logic [fcv_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic                           in_valid_r;
  logic [fcv_pkg::FRAME_W-1:0]    frame_r;
  logic                           out_valid_r;
  fcv_pkg::result_t               res_r, res_nxt;
  logic [7:0]                     actual;
  fcv_pkg::pred_info_t            info;
  logic                           res_ready, in_ready;

  assign res_ready = !out_valid_r || out_tready;
  assign in_ready  = !in_valid_r || res_ready;
  assign in_tready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_tvalid) begin
      frame_r <= in_tdata;
    end
  end

  fcv_actual u_actual (
    .frame           (frame_r),
    .actual_residual (actual)
  );

  fcv_predict u_predict (
    .frame (frame_r),
    .info  (info)
  );

  always_comb begin
    res_nxt.checksum_ok        = (actual == info.pred);
    res_nxt.actual_residual    = actual;
    res_nxt.predicted_residual = info.pred;
    res_nxt.speed_quarter      = info.speed_quarter;
    res_nxt.status_field       = info.status_field;
    res_nxt.dynamic_value      = info.dynamic_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r};

endmodule
